// ===== sv/fps_pkg.sv =====
// Shared types and constants for the fan pre-circulation sequencer.
package fps_pkg;

    localparam int unsigned HOUR_SECONDS = 3600;

    // now / 3600 is evaluated as (now >> 4) / 225 by reciprocal multiply.
    localparam int unsigned   RECIP_SHIFT = 36;
    localparam logic [28:0]   RECIP_MULT  = 29'd305419896;

    localparam int unsigned CFG_DATA_W  = 17;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_HEAT_ENABLED    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COOL_ENABLED    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RUN_SECONDS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAN_PERCENT     = 2'd3;

    typedef struct packed {
        logic [31:0] now_seconds;
        logic        heat_predicted;
        logic        cool_predicted;
        logic        call_active;
    } t_tick_req;

    typedef struct packed {
        logic [6:0]  fan_drive;
        logic        pre_running;
        logic [11:0] hour_credit;
    } t_tick_rsp;

    typedef struct packed {
        t_tick_req   req;
        logic [20:0] hour;
        logic [31:0] hour_start;
    } t_hour_info;

endpackage

// ===== sv/fps_hour_div.sv =====
// Input register and pipelined divide of the tick time into hour index and hour start.
module fps_hour_div
    import fps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_stall,
    input  t_tick_req  i_req,
    output logic       o_info_valid,
    input  logic       i_info_stall,
    output t_hour_info o_info
);

    logic        r_v0;
    t_tick_req   r_req0;
    logic        r_v1;
    t_tick_req   r_req1;
    logic [56:0] r_prod;
    logic        r_v2;
    t_hour_info  r_info;

    logic        w_rdy0;
    logic        w_rdy1;
    logic        w_rdy2;
    logic [20:0] w_quot;
    logic [32:0] w_qmul;
    logic [32:0] w_rem;
    logic        w_fix;
    t_hour_info  n_info;

    assign w_rdy2      = !r_v2 || !i_info_stall;
    assign w_rdy1      = !r_v1 || w_rdy2;
    assign w_rdy0      = !r_v0 || w_rdy1;
    assign o_req_stall = !w_rdy0;

    // quotient estimate is exact or one low; one compare fixes it
    always_comb begin
        w_quot = r_prod[56:RECIP_SHIFT];
        w_qmul = {w_quot, 12'b0} - {3'b0, w_quot, 9'b0} + {8'b0, w_quot, 4'b0};
        w_rem  = {1'b0, r_req1.now_seconds} - w_qmul;
        w_fix  = w_rem >= 33'(HOUR_SECONDS);
        n_info.req        = r_req1;
        n_info.hour       = w_fix ? w_quot + 21'd1 : w_quot;
        n_info.hour_start = w_fix ? w_qmul[31:0] + 32'(HOUR_SECONDS) : w_qmul[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r_v0 <= i_req_valid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_req_valid) begin
            r_req0 <= i_req;
        end
        if (w_rdy1 && r_v0) begin
            r_req1 <= r_req0;
            r_prod <= 57'(r_req0.now_seconds[31:4]) * 57'(RECIP_MULT);
        end
        if (w_rdy2 && r_v1) begin
            r_info <= n_info;
        end
    end

    assign o_info_valid = r_v2;
    assign o_info       = r_info;

endmodule

// ===== sv/fps_seq.sv =====
// Configuration registers, pre-run sequencer, hourly credit bucket and result register.
module fps_seq
    import fps_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_info_valid,
    output logic                   o_info_stall,
    input  t_hour_info             i_info,
    output logic                   o_rsp_valid,
    input  logic                   i_rsp_stall,
    output t_tick_rsp              o_rsp
);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_PRERUN = 2'd1,
        MODE_SPENT  = 2'd2
    } t_mode;

    logic        r_heat_en;
    logic        r_cool_en;
    logic [16:0] r_max_run;
    logic [6:0]  r_fan_pct;

    t_mode       r_mode;
    logic [20:0] r_bucket_hour;
    logic [31:0] r_run_start;
    logic [31:0] r_last;
    logic [11:0] r_credit;
    logic        r_rsp_v;
    t_tick_rsp   r_rsp;

    t_mode       n_mode;
    logic [31:0] n_run_start;
    logic [31:0] n_last;
    logic [11:0] n_credit;
    t_tick_rsp   n_rsp;

    logic        w_take;
    logic        w_pred;
    logic        w_hour_chg;
    logic [11:0] w_credit_base;
    logic [31:0] w_last_base;
    logic [31:0] w_slice;
    logic [11:0] w_room;
    logic [11:0] w_credit_add;
    logic [31:0] w_run_time;
    logic        w_run_done;
    logic        w_drop;

    assign w_take       = i_info_valid && (!r_rsp_v || !i_rsp_stall);
    assign o_info_stall = r_rsp_v && i_rsp_stall;

    always_comb begin
        w_pred = (r_heat_en && i_info.req.heat_predicted)
              || (r_cool_en && i_info.req.cool_predicted);
        w_drop = i_info.req.call_active || !w_pred;
        w_hour_chg    = i_info.hour != r_bucket_hour;
        w_credit_base = w_hour_chg ? 12'd0 : r_credit;
        w_last_base   = (w_hour_chg && r_mode == MODE_PRERUN && r_last < i_info.hour_start)
                      ? i_info.hour_start : r_last;
        w_slice      = i_info.req.now_seconds - w_last_base;
        w_room       = 12'(HOUR_SECONDS) - w_credit_base;
        w_credit_add = (w_slice >= {20'b0, w_room}) ? 12'(HOUR_SECONDS)
                                                    : w_credit_base + w_slice[11:0];
        w_run_time = i_info.req.now_seconds - r_run_start;
        w_run_done = w_run_time >= {15'b0, r_max_run};

        n_mode      = r_mode;
        n_run_start = r_run_start;
        n_last      = w_last_base;
        n_credit    = w_credit_base;
        unique case (r_mode)
            MODE_PRERUN: begin
                n_credit = w_credit_add;
                n_last   = i_info.req.now_seconds;
                if (w_drop) begin
                    n_mode = MODE_IDLE;
                end else if (w_run_done) begin
                    n_mode = MODE_SPENT;
                end
            end
            MODE_SPENT: begin
                if (w_drop) begin
                    n_mode = MODE_IDLE;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
                if (w_pred && !i_info.req.call_active) begin
                    n_mode      = MODE_PRERUN;
                    n_run_start = i_info.req.now_seconds;
                    n_last      = i_info.req.now_seconds;
                end
            end
        endcase

        n_rsp.pre_running = n_mode == MODE_PRERUN;
        n_rsp.fan_drive   = (n_mode == MODE_PRERUN) ? r_fan_pct : 7'd0;
        n_rsp.hour_credit = n_credit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat_en     <= 1'b1;
            r_cool_en     <= 1'b1;
            r_max_run     <= 17'd900;
            r_fan_pct     <= 7'd50;
            r_mode        <= MODE_IDLE;
            r_bucket_hour <= '0;
            r_run_start   <= '0;
            r_last        <= '0;
            r_credit      <= '0;
            r_rsp_v       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_HEAT_ENABLED:    r_heat_en <= i_cfg_data[0];
                    CFG_COOL_ENABLED:    r_cool_en <= i_cfg_data[0];
                    CFG_MAX_RUN_SECONDS: r_max_run <= i_cfg_data[16:0];
                    CFG_FAN_PERCENT:     r_fan_pct <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (w_take) begin
                r_mode        <= n_mode;
                r_bucket_hour <= i_info.hour;
                r_run_start   <= n_run_start;
                r_last        <= n_last;
                r_credit      <= n_credit;
            end
            if (!r_rsp_v || !i_rsp_stall) begin
                r_rsp_v <= i_info_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_v;
    assign o_rsp       = r_rsp;

    a_credit_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= 12'(HOUR_SECONDS))
        else $error("credit above one hour");

    a_spent_no_prerun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_SPENT |=> r_mode != MODE_PRERUN)
        else $error("spent went straight to pre-run");

    a_rsp_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_v |-> (r_rsp.pre_running == (r_mode == MODE_PRERUN))
                    && (r_rsp.hour_credit == r_credit))
        else $error("result register out of step with state");

    a_fan_off_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_v && !r_rsp.pre_running |-> r_rsp.fan_drive == 7'd0)
        else $error("fan driven outside pre-run");

endmodule

// ===== sv/fan_precirculation_sequencer_core.sv =====
// Top level of the fan pre-circulation sequencer.
//
// Tick requests enter on i_req (valid/stall); one result per tick leaves on
// o_rsp (valid/stall), in order. A request is taken when i_req_valid is high
// and o_req_stall is low; a result is taken when o_rsp_valid is high and
// i_rsp_stall is low.
// The request is registered at acceptance; then the reciprocal multiply for
// now/3600, the quotient correction and the sequencer update into the result
// register are each registered in turn. One request per cycle is sustained
// while the receiver does not stall; the sequencer state feeds back within
// that last single stage.
// A stalled receiver holds the result register; the stages in front keep
// taking requests until each is full, then o_req_stall rises.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data);
// the user must write it only while no request is in flight (not enforced).
// Synchronous active-low reset restores the register defaults (heat and cool
// enabled, 900 s max run, 50 percent fan), puts the sequencer in idle and
// clears the hour bucket and all in-flight requests.
module fan_precirculation_sequencer_core
    import fps_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_req_valid,
    output logic                   o_req_stall,
    input  t_tick_req              i_req,
    output logic                   o_rsp_valid,
    input  logic                   i_rsp_stall,
    output t_tick_rsp              o_rsp
);

    logic       w_info_valid;
    logic       w_info_stall;
    t_hour_info w_info;

    fps_hour_div u_hour_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_stall  (o_req_stall),
        .i_req        (i_req),
        .o_info_valid (w_info_valid),
        .i_info_stall (w_info_stall),
        .o_info       (w_info)
    );

    fps_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_info_valid (w_info_valid),
        .o_info_stall (w_info_stall),
        .i_info       (w_info),
        .o_rsp_valid  (o_rsp_valid),
        .i_rsp_stall  (i_rsp_stall),
        .o_rsp        (o_rsp)
    );

endmodule
